@@ hw/rtl/ghs_pkg.sv @@
// ----------------------------------------------------------------------------
// ghs_pkg: shared constants for the Gaussian heatmap splat block
// Grid geometry, fixed-point widths, command and register codes, and the
// exp(-0.5*e) ROM contents built at elaboration.
// ----------------------------------------------------------------------------
package ghs_pkg;

  localparam int GRID_DIM        = 20;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int TILES     = GRID_DIM * GRID_DIM;
  localparam int ADDR_W    = $clog2(TILES);
  localparam int XY_W      = $clog2(GRID_DIM);
  localparam int ROM_AW    = $clog2(EXP_TABLE_DEPTH);
  localparam int DEPTH_W   = $clog2(EXP_TABLE_DEPTH + 1);

  localparam int CMD_W     = 2;
  localparam int CENTER_W  = 14;
  localparam int TILE_W    = 6;
  localparam int PROB_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ROM_W     = 17;

  // offset magnitude, square, scaled term, index product
  localparam int DX_W       = $clog2(256 * GRID_DIM + 8192);
  localparam int SD_W       = DX_W + 1;
  localparam int SQ_W       = 2 * DX_W;
  localparam int SIGMA_FRAC = 12;
  localparam int EX_W       = SQ_W + 16 - SIGMA_FRAC;
  localparam int E_W        = EX_W + 1;
  localparam int IDX_PROD_W = E_W + DEPTH_W;
  localparam int IDX_SHIFT  = 21;
  localparam int AMP_PROD_W = PROB_W + ROM_W;
  localparam int MRG_PROD_W = 2 * PROB_W;

  localparam logic [CMD_W-1:0] CMD_SPLAT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_SIGMA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SIGMA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE   = 2'd2;

  localparam logic [CFG_W-1:0] INV_SIGMA_RESET = 16'd4096;
  localparam logic [CFG_W-1:0] AMPLITUDE_RESET = 16'd64;

  typedef logic [ROM_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-f) in Q31, f in Q32
  function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
    logic [127:0] prod;
    logic [63:0]  term;
    logic [63:0]  sum;
    term = 64'd1 << 32;
    sum  = term;
    for (int k = 1; k <= 20; k++) begin
      prod = {64'd0, term} * {64'd0, f};
      term = udiv64(prod[95:32], 64'(k));
      sum  = sum + term;
    end
    return udiv64(64'd1 << 63, sum);
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t     rom;
    logic [63:0]  half;
    logic [63:0]  e1;
    logic [63:0]  val;
    logic [63:0]  frac;
    logic [63:0]  rnd;
    logic [127:0] prod;
    int           n;
    int           rem;
    half = exp_neg_frac(64'd1 << 31);
    prod = {64'd0, half} * {64'd0, half};
    e1   = prod[94:31];
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      n    = (16 * i) / EXP_TABLE_DEPTH;
      rem  = (16 * i) % EXP_TABLE_DEPTH;
      frac = (64'(rem) << 32) / EXP_TABLE_DEPTH;
      val  = exp_neg_frac(frac);
      for (int j = 0; j < 16; j++) begin
        if (j < n) begin
          prod = {64'd0, val} * {64'd0, e1};
          val  = prod[94:31];
        end
      end
      rnd    = val + (64'd1 << 14);
      rom[i] = rnd[15 +: ROM_W];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

@@ hw/rtl/gaussian_heatmap_splat_top.sv @@
// ----------------------------------------------------------------------------
// gaussian_heatmap_splat_top: probability grid with Gaussian splat updates
// Grid held in one single-port-write, registered-read memory; splats walk it
// with a read-modify-write pipeline, clears sweep it, reads return one tile.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. After reset the block
// is busy while it zeroes the grid one entry per cycle; a clear item takes
// the same sweep. A splat visits one tile per cycle through a seven-stage
// read-modify-write pipeline on the grid memory, and busy stays high until
// that pipeline has drained. A read item passes through ST_READ, where the
// tile is read from the grid memory, and raises valid for one cycle in
// ST_RESULT with the tile on probability; the receiver must take it then.
// Command code 3 is taken and dropped. Registers are to be written through
// cfg_we/cfg_index/cfg_data by the user while idle; the block does not enforce it.
module gaussian_heatmap_splat_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ghs_pkg::CMD_W-1:0]            cmd,
  input  logic signed [ghs_pkg::CENTER_W-1:0]  blob_x,
  input  logic signed [ghs_pkg::CENTER_W-1:0]  blob_y,
  input  logic [ghs_pkg::TILE_W-1:0]           tile_x,
  input  logic [ghs_pkg::TILE_W-1:0]           tile_y,
  output logic                                 valid,
  output logic [ghs_pkg::PROB_W-1:0]           probability,
  input  logic                                 cfg_we,
  input  logic [ghs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ghs_pkg::CFG_W-1:0]            cfg_data
);
  import ghs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CLEAR  = 6'b000010,
    ST_SPLAT  = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_READ   = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0] inv_sigma_x, inv_sigma_y, amplitude;

  logic                       accept;
  logic signed [CENTER_W-1:0] cx_r, cy_r;
  logic [ADDR_W-1:0]          rd_addr;
  logic [TILE_W-1:0]          tx_sat, ty_sat;

  logic [XY_W-1:0]   xi, yi;
  logic [ADDR_W-1:0] addr_c;
  logic [ADDR_W-1:0] clr_addr;
  logic              splat_last, clr_last;

  logic [PROB_W-1:0] grid_mem [TILES];
  logic [PROB_W-1:0] mem_rdata;
  logic [ADDR_W-1:0] rd_sel;

  // pipeline
  logic [7:1]             v;
  logic [ADDR_W-1:0]      addr_p [1:7];
  logic signed [SD_W-1:0] ctr_x, ctr_y, off_x, off_y;
  logic [DX_W-1:0]        abs_x, abs_y, dx1, dy1;
  logic [SQ_W-1:0]        dx2, dy2;
  logic [SQ_W+15:0]       mx, my;
  logic [EX_W-1:0]        ex3, ey3;
  logic [E_W-1:0]         e_sum;
  logic [IDX_PROD_W-1:0]  idx_prod;
  logic                   hit4;
  logic [ROM_AW-1:0]      idx4;
  logic [ROM_W-1:0]       rom5;
  logic [AMP_PROD_W-1:0]  wsum;
  logic [PROB_W-1:0]      p1_6, p0_7, p1_7;
  logic [MRG_PROD_W-1:0]  prod7;
  logic [MRG_PROD_W:0]    mterm;
  logic [PROB_W:0]        msum;
  logic [PROB_W-1:0]      p2;

  assign accept = start && !busy;
  assign busy   = !(state == ST_IDLE);
  assign valid  = (state == ST_RESULT);
  assign probability = mem_rdata;

  assign splat_last = (addr_c == ADDR_W'(TILES - 1));
  assign clr_last   = (clr_addr == ADDR_W'(TILES - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd)
            CMD_SPLAT: state_next = ST_SPLAT;
            CMD_CLEAR: state_next = ST_CLEAR;
            CMD_READ:  state_next = ST_READ;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:  if (clr_last) state_next = ST_IDLE;
      ST_SPLAT:  if (splat_last) state_next = ST_DRAIN;
      ST_DRAIN:  if (v[6:1] == '0) state_next = ST_IDLE;
      ST_READ:   state_next = ST_RESULT;
      ST_RESULT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      v           <= '0;
      inv_sigma_x <= INV_SIGMA_RESET;
      inv_sigma_y <= INV_SIGMA_RESET;
      amplitude   <= AMPLITUDE_RESET;
    end else begin
      state <= state_next;
      v     <= {v[6:1], state == ST_SPLAT};
      if (accept) begin
        clr_addr <= '0;
      end else if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_INV_SIGMA_X: inv_sigma_x <= cfg_data;
          CFG_INV_SIGMA_Y: inv_sigma_y <= cfg_data;
          CFG_AMPLITUDE:   amplitude   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // item capture and tile walk
  assign tx_sat = (tile_x > TILE_W'(GRID_DIM - 1)) ? TILE_W'(GRID_DIM - 1) : tile_x;
  assign ty_sat = (tile_y > TILE_W'(GRID_DIM - 1)) ? TILE_W'(GRID_DIM - 1) : tile_y;

  always_ff @(posedge clk) begin
    if (accept) begin
      cx_r    <= blob_x;
      cy_r    <= blob_y;
      rd_addr <= ADDR_W'(ty_sat * GRID_DIM) + ADDR_W'(tx_sat);
      xi      <= '0;
      yi      <= '0;
      addr_c  <= '0;
    end else if (state == ST_SPLAT) begin
      addr_c <= addr_c + 1'b1;
      if (xi == XY_W'(GRID_DIM - 1)) begin
        xi <= '0;
        yi <= yi + 1'b1;
      end else begin
        xi <= xi + 1'b1;
      end
    end
  end

  // stage 1: offsets from tile center
  assign ctr_x = $signed(SD_W'({xi, 8'h80}));
  assign ctr_y = $signed(SD_W'({yi, 8'h80}));
  assign off_x = ctr_x - SD_W'(cx_r);
  assign off_y = ctr_y - SD_W'(cy_r);
  assign abs_x = off_x[SD_W-1] ? DX_W'(-off_x) : DX_W'(off_x);
  assign abs_y = off_y[SD_W-1] ? DX_W'(-off_y) : DX_W'(off_y);

  assign mx       = (SQ_W + 16)'(dx2) * (SQ_W + 16)'(inv_sigma_x);
  assign my       = (SQ_W + 16)'(dy2) * (SQ_W + 16)'(inv_sigma_y);
  assign e_sum    = E_W'(ex3) + E_W'(ey3);
  assign idx_prod = IDX_PROD_W'(e_sum) * IDX_PROD_W'(EXP_TABLE_DEPTH);
  assign wsum     = AMP_PROD_W'(amplitude) * AMP_PROD_W'(rom5) + AMP_PROD_W'(32768);

  always_ff @(posedge clk) begin
    dx1       <= abs_x;
    dy1       <= abs_y;
    addr_p[1] <= addr_c;
    for (int k = 2; k <= 7; k++) begin
      addr_p[k] <= addr_p[k-1];
    end
    dx2   <= SQ_W'(dx1) * SQ_W'(dx1);
    dy2   <= SQ_W'(dy1) * SQ_W'(dy1);
    ex3   <= mx[SQ_W+15:SIGMA_FRAC];
    ey3   <= my[SQ_W+15:SIGMA_FRAC];
    hit4  <= (idx_prod >> IDX_SHIFT) < IDX_PROD_W'(EXP_TABLE_DEPTH);
    idx4  <= idx_prod[IDX_SHIFT +: ROM_AW];
    rom5  <= hit4 ? EXP_ROM[idx4] : '0;
    p1_6  <= wsum[2*PROB_W-1:PROB_W];
    prod7 <= MRG_PROD_W'(mem_rdata) * MRG_PROD_W'(p1_6);
    p0_7  <= mem_rdata;
    p1_7  <= p1_6;
  end

  // stage 7: probabilistic OR, saturated
  assign mterm = (MRG_PROD_W + 1)'(prod7) + (MRG_PROD_W + 1)'(32768);
  assign msum  = (PROB_W + 1)'(p0_7) + (PROB_W + 1)'(p1_7) - mterm[MRG_PROD_W:PROB_W];
  assign p2    = msum[PROB_W] ? '1 : msum[PROB_W-1:0];

  assign rd_sel = v[5] ? addr_p[5] : rd_addr;

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      grid_mem[clr_addr] <= '0;
    end else if (v[7]) begin
      grid_mem[addr_p[7]] <= p2;
    end
    mem_rdata <= grid_mem[rd_sel];
  end

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_READ) |=> ##1 valid)
    else $error("read item without result strobe");

  a_rmw_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (v[5] && v[7]) |-> (addr_p[5] != addr_p[7]))
    else $error("tile read while its write is pending");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (v == '0))
    else $error("idle with splat pipeline busy");

  a_clear_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !v[7])
    else $error("splat write during clear sweep");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid)
    else $error("result strobe held over two cycles");

endmodule
